[rtl/rfcb_pkg.sv]
`timescale 1ns / 1ps

package rfcb_pkg;

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_COPY = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic signed [7:0]  w;
    logic signed [7:0]  h;
    logic signed [7:0]  x2;
    logic signed [7:0]  y2;
    logic        [31:0] color;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        status;
  } res_t;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

endpackage

[rtl/rfcb_ram.sv]
`timescale 1ns / 1ps

module rfcb_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rfcb_ctrl.sv]
`timescale 1ns / 1ps

module rfcb_ctrl #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned HEIGHT = 64,
  parameter int unsigned DEPTH  = WIDTH * HEIGHT,
  parameter int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rfcb_pkg::cmd_t in_req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output rfcb_pkg::res_t res_o,
  output logic           mem_we_o,
  output logic [AW-1:0]  mem_waddr_o,
  output logic [31:0]    mem_wdata_o,
  output logic           mem_re_o,
  output logic [AW-1:0]  mem_raddr_o,
  input  logic [31:0]    mem_rdata_i
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_RD    = 7'b0010000,
    ST_RDW   = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  localparam logic [6:0] WLIM = 7'(WIDTH);
  localparam logic [6:0] HLIM = 7'(HEIGHT);

  function automatic logic coord_ok(logic signed [7:0] c, logic [6:0] lim);
    return !c[7] && (c[6:0] <= lim);
  endfunction

  state_e         state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  src_row_q, src_row_d;
  logic [AW-1:0]  dst_row_q, dst_row_d;
  logic [6:0]     col_q, col_d;
  logic [6:0]     row_q, row_d;
  logic [6:0]     wlen_q, wlen_d;
  logic [6:0]     hlen_q, hlen_d;
  logic [31:0]    color_q, color_d;
  logic           copy_q, copy_d;
  rfcb_pkg::res_t res_q, res_d;
  logic           pipe_q, pipe_d;
  logic [AW-1:0]  pipe_dst_q, pipe_dst_d;
  logic           fwd_q, fwd_d;
  logic [31:0]    fwd_data_q;

  // command decode
  logic           is_copy;
  logic           reject;
  logic           rd_ok;
  logic [6:0]     rem_x, rem_x2, rem_y, rem_y2;
  logic [6:0]     wc, hc;
  logic [13:0]    src_lin, dst_lin;
  logic [AW-1:0]  src_base, dst_base;
  logic [AW-1:0]  src_addr, dst_addr;
  logic           last_col, last_row;

  assign is_copy = (in_req_i.op == rfcb_pkg::OP_COPY);
  assign reject  = !coord_ok(in_req_i.x, WLIM) || !coord_ok(in_req_i.y, HLIM) ||
                   in_req_i.w[7] || in_req_i.h[7] ||
                   (is_copy && (!coord_ok(in_req_i.x2, WLIM) ||
                                !coord_ok(in_req_i.y2, HLIM)));
  assign rd_ok   = !in_req_i.x[7] && (in_req_i.x[6:0] < WLIM) &&
                   !in_req_i.y[7] && (in_req_i.y[6:0] < HLIM);

  assign rem_x  = WLIM - in_req_i.x[6:0];
  assign rem_x2 = WLIM - in_req_i.x2[6:0];
  assign rem_y  = HLIM - in_req_i.y[6:0];
  assign rem_y2 = HLIM - in_req_i.y2[6:0];

  always_comb begin
    wc = in_req_i.w[6:0];
    if (rem_x < wc) begin
      wc = rem_x;
    end
    if (is_copy && (rem_x2 < wc)) begin
      wc = rem_x2;
    end
    hc = in_req_i.h[6:0];
    if (rem_y < hc) begin
      hc = rem_y;
    end
    if (is_copy && (rem_y2 < hc)) begin
      hc = rem_y2;
    end
  end

  assign src_lin  = ({7'd0, in_req_i.y[6:0]} * 14'(WIDTH)) + {7'd0, in_req_i.x[6:0]};
  assign dst_lin  = ({7'd0, in_req_i.y2[6:0]} * 14'(WIDTH)) + {7'd0, in_req_i.x2[6:0]};
  assign src_base = AW'(src_lin);
  assign dst_base = AW'(dst_lin);

  assign src_addr = src_row_q + AW'(col_q);
  assign dst_addr = dst_row_q + AW'(col_q);
  assign last_col = (col_q == wlen_q - 7'd1);
  assign last_row = (row_q == hlen_q - 7'd1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    src_row_d   = src_row_q;
    dst_row_d   = dst_row_q;
    col_d       = col_q;
    row_d       = row_q;
    wlen_d      = wlen_q;
    hlen_d      = hlen_q;
    color_d     = color_q;
    copy_d      = copy_q;
    res_d       = res_q;
    pipe_d      = 1'b0;
    pipe_dst_d  = pipe_dst_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    // write back the pixel fetched for a copy in the previous cycle
    if (pipe_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = pipe_dst_q;
      mem_wdata_o = fwd_q ? fwd_data_q : mem_rdata_i;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          src_row_d = src_base;
          dst_row_d = is_copy ? dst_base : src_base;
          col_d     = '0;
          row_d     = '0;
          wlen_d    = wc;
          hlen_d    = hc;
          color_d   = in_req_i.color;
          copy_d    = is_copy;
          unique case (in_req_i.op)
            rfcb_pkg::OP_FILL, rfcb_pkg::OP_COPY: begin
              if (reject) begin
                res_d   = '{pixel: '0, status: rfcb_pkg::STATUS_REJECT};
                state_d = ST_RESP;
              end else if ((wc == 7'd0) || (hc == 7'd0)) begin
                res_d   = '{pixel: '0, status: rfcb_pkg::STATUS_DONE};
                state_d = ST_RESP;
              end else begin
                state_d = ST_WALK;
              end
            end
            rfcb_pkg::OP_READ: begin
              if (rd_ok) begin
                state_d = ST_RD;
              end else begin
                res_d   = '{pixel: '0, status: rfcb_pkg::STATUS_REJECT};
                state_d = ST_RESP;
              end
            end
            rfcb_pkg::OP_NONE: begin
              res_d   = '{pixel: '0, status: rfcb_pkg::STATUS_REJECT};
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (copy_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = src_addr;
          pipe_d      = 1'b1;
          pipe_dst_d  = dst_addr;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dst_addr;
          mem_wdata_o = color_q;
        end
        if (last_col) begin
          col_d     = '0;
          row_d     = row_q + 7'd1;
          src_row_d = src_row_q + AW'(WIDTH);
          dst_row_d = dst_row_q + AW'(WIDTH);
          if (last_row) begin
            res_d   = '{pixel: '0, status: rfcb_pkg::STATUS_DONE};
            state_d = copy_q ? ST_DRAIN : ST_RESP;
          end
        end else begin
          col_d = col_q + 7'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESP;
      end
      ST_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = src_row_q;
        state_d     = ST_RDW;
      end
      ST_RDW: begin
        res_d   = '{pixel: mem_rdata_i, status: rfcb_pkg::STATUS_DONE};
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // forward a word written in the same cycle as its read
  assign fwd_d = mem_re_o && mem_we_o && (mem_raddr_o == mem_waddr_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pipe_q  <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pipe_q  <= pipe_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_row_q  <= src_row_d;
    dst_row_q  <= dst_row_d;
    col_q      <= col_d;
    row_q      <= row_d;
    wlen_q     <= wlen_d;
    hlen_q     <= hlen_d;
    color_q    <= color_d;
    copy_q     <= copy_d;
    res_q      <= res_d;
    pipe_dst_q <= pipe_dst_d;
    fwd_data_q <= mem_wdata_o;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

endmodule

[rtl/rect_fill_copy_blitter_top.sv]
`timescale 1ns / 1ps

// Rectangle fill / copy / pixel-read engine over an internal WIDTH x HEIGHT
// store of 32-bit pixels.
// Request channel: in_valid_i / in_stall_o with one cmd_t per request.
// Result channel: out_valid_o / out_stall_i, one res_t for every request.
// A request is taken only while the engine is idle; one request is worked at a
// time, since each rectangle walks the single-write-port store pixel by pixel.
// Fill: one write per clipped pixel, then the result is handed off.
// Copy: one read per clipped pixel, its write-back overlapping the next read
//   (with a forwarding path), then a drain state and the hand-off.
// Read: fetch, wait, hand-off; rejected, empty or unknown requests: hand-off.
// The result lands in an output register the cycle after hand-off, so the
// next request is taken while the previous result still waits downstream.
// After reset the store is cleared to zero, one word per cycle, over all
// WIDTH*HEIGHT words; in_stall_o stays high until the clear is done.
// A stalled result holds in the output register; once the engine has a
// second result ready it waits for the register to drain.
module rect_fill_copy_blitter_top #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned HEIGHT = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rfcb_pkg::cmd_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rfcb_pkg::res_t out_res_o
);

  localparam int unsigned DEPTH = WIDTH * HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic           res_valid;
  logic           res_ready;
  rfcb_pkg::res_t res;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    mem_rdata;
  logic           out_valid_q, out_valid_d;
  rfcb_pkg::res_t out_res_q;

  rfcb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rfcb_ctrl #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  // a result that cannot be handed off holds in the engine
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("engine result changed while waiting for hand-off");

  // no request is taken while a result is pending in the engine
  a_no_accept_on_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !res_valid)
    else $error("request accepted while a result is pending");

  // a taken request blocks the next one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("engine not busy after accepting a request");
`endif

endmodule
